/* hdl/sul_pkg.sv */
// Package with the shared constants, status codes and cell control types of the sorted list.
`timescale 1ns / 1ps
package sul_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned ValW = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW = 4;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned ReqIdxW = 4;

  typedef enum logic [StatusW-1:0] {
    StInserted  = 3'd0,
    StDuplicate = 3'd1,
    StFull      = 3'd2,
    StReadOk    = 3'd3,
    StReadBad   = 3'd4
  } status_e;

  typedef struct packed {
    logic ins;
    logic valid;
    logic at_end;
    logic prev_gt;
  } cell_ctrl_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cell_flags_t;

endpackage

/* hdl/sul_cell.sv */
// One slot of the sorted list: holds an entry, compares it and shifts from its lower neighbour.
`timescale 1ns / 1ps
module sul_cell (
  input  logic                                clk_i,
  input  sul_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [sul_pkg::ValW-1:0]     value_i,
  input  logic signed [sul_pkg::ValW-1:0]     prev_entry_i,
  output sul_pkg::cell_flags_t                flags_o,
  output logic signed [sul_pkg::ValW-1:0]     entry_o
);
  import sul_pkg::*;

  logic signed [ValW-1:0] entry_q;
  logic signed [ValW-1:0] entry_d;

  assign flags_o.eq = ctrl_i.valid && (entry_q == value_i);
  assign flags_o.gt = ctrl_i.valid && (entry_q > value_i);
  assign entry_o    = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (ctrl_i.prev_gt) begin
        entry_d = prev_entry_i;
      end else if (flags_o.gt || ctrl_i.at_end) begin
        entry_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* hdl/sorted_unique_insert_list_core.sv */
// Top level of the sorted unique insertion list: the row of cells, the count and the result register.
`timescale 1ns / 1ps
// Keeps up to sixteen signed values in ascending order without repeats. Each request is
// answered by one result in the cycle after it is accepted, and a new request is taken in every
// cycle in which the result register is empty or its result is being taken, so the block
// sustains one request per cycle while results are taken. That rate is set by the row of cells,
// which compare the request value against every entry and shift the larger entries up by one slot
// in the same cycle. No clearing pass follows reset: slots at and above the count are never read.
module sorted_unique_insert_list_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   req_type_i,
  input  logic signed [sul_pkg::ValW-1:0]        value_i,
  input  logic [sul_pkg::ReqIdxW-1:0]            index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [sul_pkg::StatusW-1:0]            status_o,
  output logic [sul_pkg::PosW-1:0]               position_o,
  output logic [sul_pkg::CountOutW-1:0]          entry_count_o,
  output logic signed [sul_pkg::ValW-1:0]        read_value_o
);
  import sul_pkg::*;

  logic                   accept;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        count_d;
  logic                   out_valid_q;
  status_e                status_q;
  status_e                status_d;
  logic [PosW-1:0]        position_q;
  logic [PosW-1:0]        position_d;
  logic signed [ValW-1:0] read_value_q;
  logic signed [ValW-1:0] read_value_d;

  cell_ctrl_t             ctrl  [Depth];
  cell_flags_t            flags [Depth];
  logic signed [ValW-1:0] ent   [Depth];
  logic [Depth-1:0]       eq_vec;
  logic [Depth-1:0]       gt_vec;
  logic [Depth-1:0]       first_gt;
  logic                   is_dup;
  logic                   is_full;
  logic                   do_ins;
  logic [IdxW-1:0]        dup_pos;
  logic [IdxW-1:0]        gt_pos;
  logic [IdxW-1:0]        slot;
  logic [IdxW-1:0]        rd_idx;
  logic                   rd_ok;
  logic signed [ValW-1:0] rd_data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign ctrl[i].ins     = do_ins;
    assign ctrl[i].valid   = CntW'(i) < count_q;
    assign ctrl[i].at_end  = count_q == CntW'(i);
    assign eq_vec[i]       = flags[i].eq;
    assign gt_vec[i]       = flags[i].gt;
    if (i == 0) begin : g_first
      assign ctrl[i].prev_gt = 1'b0;
      assign first_gt[i]     = gt_vec[i];
      sul_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl[i]),
        .value_i      (value_i),
        .prev_entry_i (value_i),
        .flags_o      (flags[i]),
        .entry_o      (ent[i])
      );
    end else begin : g_rest
      assign ctrl[i].prev_gt = gt_vec[i-1];
      assign first_gt[i]     = gt_vec[i] && !gt_vec[i-1];
      sul_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl[i]),
        .value_i      (value_i),
        .prev_entry_i (ent[i-1]),
        .flags_o      (flags[i]),
        .entry_o      (ent[i])
      );
    end
  end

  assign is_dup  = |eq_vec;
  assign is_full = count_q == CntW'(Depth);
  assign do_ins  = accept && !req_type_i && !is_dup && !is_full;

  always_comb begin
    dup_pos = '0;
    gt_pos  = '0;
    rd_data = '0;
    for (int i = 0; i < Depth; i++) begin
      if (eq_vec[i]) begin
        dup_pos = dup_pos | IdxW'(i);
      end
      if (first_gt[i]) begin
        gt_pos = gt_pos | IdxW'(i);
      end
      if (rd_idx == IdxW'(i)) begin
        rd_data = ent[i];
      end
    end
  end

  assign slot   = (|gt_vec) ? gt_pos : IdxW'(count_q);
  assign rd_idx = IdxW'(index_i);
  assign rd_ok  = 32'(index_i) < 32'(count_q);

  always_comb begin
    count_d      = count_q;
    status_d     = StInserted;
    position_d   = '0;
    read_value_d = '0;
    if (req_type_i) begin
      position_d = PosW'(index_i);
      if (rd_ok) begin
        status_d     = StReadOk;
        read_value_d = rd_data;
      end else begin
        status_d = StReadBad;
      end
    end else if (is_dup) begin
      status_d   = StDuplicate;
      position_d = PosW'(dup_pos);
    end else if (is_full) begin
      status_d = StFull;
    end else begin
      status_d   = StInserted;
      position_d = PosW'(slot);
      count_d    = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      position_q   <= position_d;
      read_value_q <= read_value_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign entry_count_o = CountOutW'(count_q);
  assign read_value_o  = read_value_q;

endmodule

/* test/sorted_unique_insert_list_core_tb.sv */
// Self-checking testbench for the sorted unique insertion list core.
`timescale 1ns / 1ps
module sorted_unique_insert_list_core_tb;
  import sul_pkg::*;

  typedef enum logic {
    ReqInsert = 1'b0,
    ReqRead   = 1'b1
  } req_e;

  typedef struct {
    status_e                status;
    logic [PosW-1:0]        pos;
    logic [CountOutW-1:0]   cnt;
    logic signed [ValW-1:0] rv;
  } outcome_t;

  class list_scoreboard;
    logic signed [ValW-1:0] stored[Depth];
    int unsigned filled;
    outcome_t awaited[$];
    int errors;
    int n_inserted, n_duplicate, n_full, n_read_ok, n_read_bad;

    function new();
      filled = 0;
      errors = 0;
      n_inserted = 0;
      n_duplicate = 0;
      n_full = 0;
      n_read_ok = 0;
      n_read_bad = 0;
    endfunction

    function void note_request(req_e req, logic signed [ValW-1:0] val,
                               logic [ReqIdxW-1:0] idx);
      outcome_t res;
      int found;
      int slot;
      res.rv = '0;
      res.pos = '0;
      found = -1;
      if (req == ReqRead) begin
        res.pos = idx;
        if (idx < filled) begin
          res.status = StReadOk;
          res.rv = stored[idx];
          n_read_ok++;
        end else begin
          res.status = StReadBad;
          n_read_bad++;
        end
      end else begin
        for (int i = 0; i < filled; i++) begin
          if (found < 0 && stored[i] == val) found = i;
        end
        if (found >= 0) begin
          res.status = StDuplicate;
          res.pos = PosW'(found);
          n_duplicate++;
        end else if (filled >= Depth) begin
          res.status = StFull;
          n_full++;
        end else begin
          slot = filled;
          for (int i = filled - 1; i >= 0; i--) begin
            if (stored[i] > val) slot = i;
          end
          for (int i = filled; i > slot; i--) stored[i] = stored[i-1];
          stored[slot] = val;
          filled++;
          res.status = StInserted;
          res.pos = PosW'(slot);
          n_inserted++;
        end
      end
      res.cnt = CountOutW'(filled);
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, logic [ValW-1:0] want, logic [ValW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [StatusW-1:0] status, logic [PosW-1:0] pos,
                               logic [CountOutW-1:0] cnt, logic signed [ValW-1:0] rv);
      outcome_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual status %0d",
                 $time, status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", ValW'(want.status), ValW'(status));
      compare_field("position", ValW'(want.pos), ValW'(pos));
      compare_field("entry_count", ValW'(want.cnt), ValW'(cnt));
      compare_field("read_value", want.rv, rv);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   req_type = 1'b0;
  logic signed [ValW-1:0] value = '0;
  logic [ReqIdxW-1:0]     index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [StatusW-1:0]     status;
  logic [PosW-1:0]        position;
  logic [CountOutW-1:0]   entry_count;
  logic signed [ValW-1:0] read_value;

  logic [9:0]             rx_phase = '0;
  int                     burst_left = 0;
  list_scoreboard         sb = new();

  sorted_unique_insert_list_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .value_i       (value),
    .index_i       (index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .position_o    (position),
    .entry_count_o (entry_count),
    .read_value_o  (read_value)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_phase[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (rx_phase[2:0] != 3'd0);
      default: out_ready <= (rx_phase[7:4] != 4'hf) && ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(status, position, entry_count, read_value);
    end
  end

  task automatic issue(req_e req, logic signed [ValW-1:0] val, logic [ReqIdxW-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= req;
    value <= val;
    index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, val, idx);
  endtask

  function automatic logic signed [ValW-1:0] pick_insert_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 && sb.filled > 0) return sb.stored[$urandom_range(0, sb.filled - 1)];
    if (sel < 5) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh8000_0001;
        3: return 32'sh7fff_fffe;
        4: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    if (sel < 7) return $urandom_range(0, 40) - 20;
    return $urandom();
  endfunction

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(ReqRead, $urandom(), 4'd0);
    issue(ReqRead, $urandom(), 4'd15);
    issue(ReqInsert, 32'sd0, 4'd15);
    issue(ReqInsert, 32'sh7fff_ffff, 4'd0);
    issue(ReqInsert, 32'sh8000_0000, 4'd7);
    issue(ReqInsert, -32'sd1, 4'd3);
    issue(ReqInsert, 32'sd1, 4'd9);
    issue(ReqInsert, 32'sd0, 4'd0);
    issue(ReqInsert, 32'sh8000_0000, 4'd0);
    issue(ReqInsert, 32'sh7fff_ffff, 4'd0);
    for (int i = 0; i < 5; i++) issue(ReqRead, 32'sh7fff_ffff, 4'(i));
    issue(ReqRead, 32'sh8000_0000, 4'd5);
    issue(ReqRead, -32'sd1, 4'd15);

    for (int n = 0; n < 1850; n++) begin
      if ($urandom_range(0, 1) == 1) begin
        issue(ReqInsert, pick_insert_value(), 4'($urandom()));
      end else begin
        issue(ReqRead, $urandom(), 4'($urandom_range(0, 15)));
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (sb.awaited.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.awaited.size() > 0) begin
      $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, sb.awaited.size(), sb.awaited.size());
      sb.errors++;
    end
    repeat (5) @(posedge clk);

    $display("Covered %0d inserts into the list, %0d duplicates, %0d refusals when full,",
             sb.n_inserted, sb.n_duplicate, sb.n_full);
    $display("%0d reads in range and %0d reads beyond the count; %0d mismatches.",
             sb.n_read_ok, sb.n_read_bad, sb.errors);
    if (sb.errors == 0) begin
      $display("[sorted_unique_insert_list_core] OK");
    end else begin
      $display("[sorted_unique_insert_list_core] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: simulation timed out", $time);
    $display("[sorted_unique_insert_list_core] ERROR");
    $finish;
  end

endmodule
